// ===== hdl/gks_pkg.sv =====
// Shared types, constants and codes for the Gaussian kernel smoother.
package gks_pkg;

  localparam int MAX_COLS_DEF     = 64;
  localparam int MAX_ROWS_DEF     = 64;
  localparam int WEIGHT_TABLE_DEF = 4096;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WEIGHT_W = 17;

  localparam logic [6:0]  COLS_RESET  = 7'd64;
  localparam logic [6:0]  ROWS_RESET  = 7'd64;
  localparam logic [31:0] WINDOW_RESET = 32'd65536;
  localparam logic [31:0] SCALE_RESET  = 32'd8388608;

  // exp(-1/256) in Q2.62, built from the truncated series, and exp(0) in Q2.62.
  localparam logic [63:0] EXP_RATIO = 64'd4593706759521714574;
  localparam logic [63:0] EXP_START = 64'h4000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS, REG_ROWS, REG_WIN_X, REG_WIN_Y, REG_SCALE_X, REG_SCALE_Y
  } reg_idx_t;

  typedef enum logic [3:0] {
    MOP_NONE, MOP_ELL, MOP_ELH, MOP_EHL, MOP_EHH,
    MOP_DXX, MOP_SXL, MOP_SXH, MOP_DYY, MOP_SYL, MOP_SYH
  } mul_op_t;

  typedef enum logic [4:0] {
    S_FILL_W, S_FILL_M, S_FILL_A, S_FILL_E, S_IDLE, S_REF_RD, S_REF_LD,
    S_ROWB, S_RD, S_CHK, S_WIN, S_MUL, S_MWAIT, S_ROMR, S_ACC, S_ACC2,
    S_STEP, S_FIN, S_DIVW, S_RES, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic    wr;
    logic    rd;
    logic    ref_ld;
    logic    cur_ld;
    mul_op_t op;
    logic    rom_rd;
    logic    wv_mul;
    logic    acc;
    logic    clr;
    logic    div_start;
    logic    res_ld;
    logic    fill_wr;
    logic    fill_adv;
    logic    acc_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic in_win;
    logic cur_valid;
    logic sw_zero;
    logic div_busy;
    logic fill_last;
  } dp_stat_t;

endpackage

// ===== hdl/gaussian_kernel_smoother_2d.sv =====
// Top level of the Gaussian kernel smoother over a 2-D grid of points.
//
//  channel   ports                                            transfer
//  command   start, busy, command, col, row, x_coord,         start && !busy
//            y_coord, sample_value, sample_valid
//  result    done, smoothed_value, no_weight                  done, one cycle
//  config    cfg_write, cfg_index, cfg_data                   cfg_write
//
// A query walks the window row by row from the query cell, reading each cell;
// each valid cell in the window passes through the multiplier and the sums, and
// the divider runs when the weight sum is not zero (one quotient bit per cycle).
// A query outside the grid in use reads no cell.
// The single read port of the point store and the shared 32 by 32 multiplier
// set the cost of a cell. After reset the weight table is built, with busy
// high throughout.
// The receiver cannot stall: each result word is shown for one cycle only.
module gaussian_kernel_smoother_2d #(
  parameter int MAX_COLS          = gks_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS          = gks_pkg::MAX_ROWS_DEF,
  parameter int WEIGHT_TABLE_SIZE = gks_pkg::WEIGHT_TABLE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [5:0]                        col,
  input  logic [5:0]                        row,
  input  logic signed [31:0]                x_coord,
  input  logic signed [31:0]                y_coord,
  input  logic signed [31:0]                sample_value,
  input  logic                              sample_valid,
  output logic                              done,
  output logic signed [31:0]                smoothed_value,
  output logic                              no_weight,
  input  logic                              cfg_write,
  input  logic [gks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gks_pkg::CFG_DATA_W-1:0]    cfg_data
);
  logic [$clog2(MAX_COLS+1)-1:0] cols;
  logic [$clog2(MAX_ROWS+1)-1:0] rows;
  logic [31:0] window_x, window_y, scale_x, scale_y;
  gks_pkg::dp_cmd_t  cmd;
  gks_pkg::dp_stat_t stat;
  logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] addr;

  gks_cfg #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_cfg (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cols(cols), .rows(rows), .window_x(window_x),
    .window_y(window_y), .scale_x(scale_x), .scale_y(scale_y)
  );

  gks_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(command), .col(col),
    .row(row), .cols(cols), .rows(rows), .stat(stat), .cmd(cmd),
    .addr(addr), .busy(busy), .done(done)
  );

  gks_dp #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
    .WEIGHT_TABLE_SIZE(WEIGHT_TABLE_SIZE)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .addr(addr), .x_coord(x_coord),
    .y_coord(y_coord), .sample_value(sample_value),
    .sample_valid(sample_valid), .window_x(window_x), .window_y(window_y),
    .scale_x(scale_x), .scale_y(scale_y), .stat(stat),
    .smoothed_value(smoothed_value), .no_weight(no_weight)
  );

endmodule

// ===== hdl/gks_cfg.sv =====
// Configuration registers and grid size saturation.
module gks_cfg #(
  parameter int MAX_COLS = gks_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gks_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gks_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [$clog2(MAX_COLS+1)-1:0]     cols,
  output logic [$clog2(MAX_ROWS+1)-1:0]     rows,
  output logic [31:0]                       window_x,
  output logic [31:0]                       window_y,
  output logic [31:0]                       scale_x,
  output logic [31:0]                       scale_y
);
  localparam int CW = $clog2(MAX_COLS+1);
  localparam int RW = $clog2(MAX_ROWS+1);

  logic [6:0] cols_in_use;
  logic [6:0] rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= gks_pkg::COLS_RESET;
      rows_in_use <= gks_pkg::ROWS_RESET;
      window_x    <= gks_pkg::WINDOW_RESET;
      window_y    <= gks_pkg::WINDOW_RESET;
      scale_x     <= gks_pkg::SCALE_RESET;
      scale_y     <= gks_pkg::SCALE_RESET;
    end else if (cfg_write) begin
      case (gks_pkg::reg_idx_t'(cfg_index))
        gks_pkg::REG_COLS:    cols_in_use <= cfg_data[6:0];
        gks_pkg::REG_ROWS:    rows_in_use <= cfg_data[6:0];
        gks_pkg::REG_WIN_X:   window_x <= cfg_data;
        gks_pkg::REG_WIN_Y:   window_y <= cfg_data;
        gks_pkg::REG_SCALE_X: scale_x <= cfg_data;
        gks_pkg::REG_SCALE_Y: scale_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_in_use == 7'd0) begin
      cols = CW'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(cols_in_use);
    end
    if (rows_in_use == 7'd0) begin
      rows = RW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(rows_in_use);
    end
  end

endmodule

// ===== hdl/gks_dp.sv =====
// Datapath: point store, weight table, shared multiplier, sums and divider.
module gks_dp #(
  parameter int MAX_COLS          = gks_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS          = gks_pkg::MAX_ROWS_DEF,
  parameter int WEIGHT_TABLE_SIZE = gks_pkg::WEIGHT_TABLE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gks_pkg::dp_cmd_t                       cmd,
  input  logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]   addr,
  input  logic signed [31:0]                     x_coord,
  input  logic signed [31:0]                     y_coord,
  input  logic signed [31:0]                     sample_value,
  input  logic                                   sample_valid,
  input  logic [31:0]                            window_x,
  input  logic [31:0]                            window_y,
  input  logic [31:0]                            scale_x,
  input  logic [31:0]                            scale_y,
  output gks_pkg::dp_stat_t                      stat,
  output logic signed [31:0]                     smoothed_value,
  output logic                                   no_weight
);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int TW    = $clog2(WEIGHT_TABLE_SIZE);
  localparam int WW    = gks_pkg::WEIGHT_W;
  localparam int SWW   = $clog2(CELLS) + WW;
  localparam int SVW   = SWW + 32;
  localparam int DCW   = $clog2(SVW + 1);

  // Point store: x, y, value and valid flag side by side in one word.
  logic [96:0] grid [CELLS];
  logic [96:0] rd_q;
  logic [WW-1:0] wrom [WEIGHT_TABLE_SIZE];

  logic signed [31:0] rd_x, rd_y, rd_v;
  logic signed [31:0] ref_x, ref_y, cur_value;
  logic signed [32:0] ddx, ddy;
  logic [31:0] adx, ady, dx, dy;
  logic in_win, cur_valid;

  logic [31:0] mul_a, mul_b;
  logic [63:0] p, d2;
  logic [31:0] lo_hi;
  logic [47:0] qx, qy, qpart;
  logic [48:0] qsum;
  gks_pkg::mul_op_t op_q;
  logic [127:0] acc;
  logic [63:0] e;
  logic [TW-1:0] fill_idx;

  logic [WW-1:0] w_q, w_eff;
  logic w_ok;
  logic signed [49:0] wv;
  logic [SWW-1:0] sw;
  logic signed [SVW-1:0] swv;

  logic [SVW-1:0] n;
  logic [SWW-1:0] rem;
  logic [SWW:0] rem_sh;
  logic neg, div_busy;
  logic [DCW-1:0] dcnt;
  logic qbit;

  assign rd_x = rd_q[96:65];
  assign rd_y = rd_q[64:33];
  assign rd_v = rd_q[32:1];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      grid[addr] <= {x_coord, y_coord, sample_value, sample_valid};
    end
    if (cmd.rd) begin
      rd_q <= grid[addr];
    end
  end

  always_comb begin
    ddx = {rd_x[31], rd_x} - {ref_x[31], ref_x};
    ddy = {rd_y[31], rd_y} - {ref_y[31], ref_y};
    adx = ddx[32] ? 32'(-ddx) : ddx[31:0];
    ady = ddy[32] ? 32'(-ddy) : ddy[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.ref_ld) begin
      ref_x <= rd_x;
      ref_y <= rd_y;
    end
    if (cmd.cur_ld) begin
      dx        <= adx;
      dy        <= ady;
      in_win    <= (adx < window_x) && (ady < window_y);
      cur_valid <= rd_q[0];
      cur_value <= rd_v;
    end
  end

  // One 32 by 32 multiplier serves the table build and the distance terms.
  always_comb begin
    case (cmd.op)
      gks_pkg::MOP_ELL: begin mul_a = e[31:0];   mul_b = gks_pkg::EXP_RATIO[31:0];  end
      gks_pkg::MOP_ELH: begin mul_a = e[31:0];   mul_b = gks_pkg::EXP_RATIO[63:32]; end
      gks_pkg::MOP_EHL: begin mul_a = e[63:32];  mul_b = gks_pkg::EXP_RATIO[31:0];  end
      gks_pkg::MOP_EHH: begin mul_a = e[63:32];  mul_b = gks_pkg::EXP_RATIO[63:32]; end
      gks_pkg::MOP_DXX: begin mul_a = dx;        mul_b = dx;      end
      gks_pkg::MOP_SXL: begin mul_a = p[31:0];   mul_b = scale_x; end
      gks_pkg::MOP_SXH: begin mul_a = d2[63:32]; mul_b = scale_x; end
      gks_pkg::MOP_DYY: begin mul_a = dy;        mul_b = dy;      end
      gks_pkg::MOP_SYL: begin mul_a = p[31:0];   mul_b = scale_y; end
      gks_pkg::MOP_SYH: begin mul_a = d2[63:32]; mul_b = scale_y; end
      default:          begin mul_a = '0;        mul_b = '0;      end
    endcase
  end

  assign qpart = 48'(({1'b0, p} + 65'(lo_hi)) >> 16);
  assign qsum  = {1'b0, qx} + {1'b0, qy};

  always_ff @(posedge clk) begin
    p <= 64'(mul_a) * 64'(mul_b);
    if (rst) begin
      op_q <= gks_pkg::MOP_NONE;
    end else begin
      op_q <= cmd.op;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else begin
      case (op_q)
        gks_pkg::MOP_ELL: acc <= acc + 128'(p);
        gks_pkg::MOP_ELH: acc <= acc + {32'd0, p, 32'd0};
        gks_pkg::MOP_EHL: acc <= acc + {32'd0, p, 32'd0};
        gks_pkg::MOP_EHH: acc <= acc + {p, 64'd0};
        default: ;
      endcase
    end
    case (op_q)
      gks_pkg::MOP_DXX: d2 <= p;
      gks_pkg::MOP_DYY: d2 <= p;
      gks_pkg::MOP_SXL: lo_hi <= p[63:32];
      gks_pkg::MOP_SYL: lo_hi <= p[63:32];
      gks_pkg::MOP_SXH: qx <= qpart;
      gks_pkg::MOP_SYH: qy <= qpart;
      default: ;
    endcase
  end

  // Weight table build: each entry is the Q2.62 exponent rounded to Q1.16, and
  // the exponent steps by one ratio product per entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      e        <= gks_pkg::EXP_START;
      fill_idx <= '0;
    end else if (cmd.fill_adv) begin
      e        <= acc[125:62];
      fill_idx <= fill_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      wrom[fill_idx] <= WW'((e + (64'd1 << 45)) >> 46);
    end
    if (cmd.rom_rd) begin
      w_q  <= wrom[qsum[TW-1:0]];
      w_ok <= qsum < 49'(WEIGHT_TABLE_SIZE);
    end
  end

  assign w_eff = w_ok ? w_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.wv_mul) begin
      wv <= 50'($signed({1'b0, w_eff})) * 50'(cur_value);
    end
    if (cmd.clr) begin
      sw  <= '0;
      swv <= '0;
    end else if (cmd.acc) begin
      sw  <= sw + SWW'(w_eff);
      swv <= swv + SVW'(wv);
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign rem_sh = {rem, n[SVW-1]};
  assign qbit   = rem_sh >= {1'b0, sw};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      dcnt     <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      dcnt     <= DCW'(SVW);
    end else if (div_busy) begin
      dcnt <= dcnt - 1'b1;
      if (dcnt == DCW'(1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      n   <= swv[SVW-1] ? SVW'(-swv) : swv;
      neg <= swv[SVW-1];
      rem <= '0;
    end else if (div_busy) begin
      rem <= qbit ? SWW'(rem_sh - {1'b0, sw}) : SWW'(rem_sh);
      n   <= {n[SVW-2:0], qbit};
    end
    if (cmd.res_ld) begin
      if (sw == '0) begin
        smoothed_value <= '0;
      end else begin
        smoothed_value <= neg ? -n[31:0] : n[31:0];
      end
      no_weight <= sw == '0;
    end
  end

  always_comb begin
    stat.in_win    = in_win;
    stat.cur_valid = cur_valid;
    stat.sw_zero   = sw == '0;
    stat.div_busy  = div_busy;
    stat.fill_last = fill_idx == TW'(WEIGHT_TABLE_SIZE - 1);
  end

endmodule

// ===== hdl/gks_ctrl.sv =====
// Controller: table build sequence, neighbour walk and result sequencing.
module gks_ctrl #(
  parameter int MAX_COLS = gks_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gks_pkg::MAX_ROWS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   command,
  input  logic [5:0]                             col,
  input  logic [5:0]                             row,
  input  logic [$clog2(MAX_COLS+1)-1:0]          cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]          rows,
  input  gks_pkg::dp_stat_t                      stat,
  output gks_pkg::dp_cmd_t                       cmd,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]   addr,
  output logic                                   busy,
  output logic                                   done
);
  localparam int CW  = $clog2(MAX_COLS+1);
  localparam int RW  = $clog2(MAX_ROWS+1);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RIW = $clog2(MAX_ROWS);
  localparam int AW  = $clog2(MAX_COLS*MAX_ROWS);

  gks_pkg::ctrl_state_t state, state_next;
  logic [CIW-1:0] c, c_next, q_col, q_col_next;
  logic [RIW-1:0] r, r_next, q_row, q_row_next;
  logic right, right_next, up, up_next, any, any_next, hit, hit_next;
  logic [2:0] cnt, cnt_next;
  logic do_left, do_rowend, do_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gks_pkg::S_FILL_W;
      c     <= '0;
      r     <= '0;
      q_col <= '0;
      q_row <= '0;
      right <= 1'b0;
      up    <= 1'b0;
      any   <= 1'b0;
      hit   <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      c     <= c_next;
      r     <= r_next;
      q_col <= q_col_next;
      q_row <= q_row_next;
      right <= right_next;
      up    <= up_next;
      any   <= any_next;
      hit   <= hit_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    if (state == gks_pkg::S_IDLE) begin
      addr = AW'(32'(row) * MAX_COLS + 32'(col));
    end else begin
      addr = AW'(32'(r) * MAX_COLS + 32'(c));
    end
  end

  assign busy = state != gks_pkg::S_IDLE;
  assign done = state == gks_pkg::S_OUT;

  always_comb begin
    state_next = state;
    c_next     = c;
    r_next     = r;
    q_col_next = q_col;
    q_row_next = q_row;
    right_next = right;
    up_next    = up;
    any_next   = any;
    hit_next   = hit;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.op     = gks_pkg::MOP_NONE;
    do_left    = 1'b0;
    do_rowend  = 1'b0;
    do_phase   = 1'b0;
    case (state)
      gks_pkg::S_FILL_W: begin
        cmd.fill_wr = 1'b1;
        cmd.acc_clr = 1'b1;
        cnt_next    = '0;
        state_next  = gks_pkg::S_FILL_M;
      end
      gks_pkg::S_FILL_M: begin
        case (cnt)
          3'd0:    cmd.op = gks_pkg::MOP_ELL;
          3'd1:    cmd.op = gks_pkg::MOP_ELH;
          3'd2:    cmd.op = gks_pkg::MOP_EHL;
          default: cmd.op = gks_pkg::MOP_EHH;
        endcase
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd3) begin
          state_next = gks_pkg::S_FILL_A;
        end
      end
      gks_pkg::S_FILL_A: state_next = gks_pkg::S_FILL_E;
      gks_pkg::S_FILL_E: begin
        cmd.fill_adv = 1'b1;
        state_next   = stat.fill_last ? gks_pkg::S_IDLE : gks_pkg::S_FILL_W;
      end
      gks_pkg::S_IDLE: begin
        if (start) begin
          if (!command) begin
            cmd.wr = (32'(col) < MAX_COLS) && (32'(row) < MAX_ROWS);
          end else begin
            cmd.clr    = 1'b1;
            q_col_next = CIW'(col);
            q_row_next = RIW'(row);
            c_next     = CIW'(col);
            r_next     = RIW'(row);
            up_next    = 1'b1;
            if ((32'(col) < 32'(cols)) && (32'(row) < 32'(rows))) begin
              state_next = gks_pkg::S_REF_RD;
            end else begin
              state_next = gks_pkg::S_FIN;
            end
          end
        end
      end
      gks_pkg::S_REF_RD: begin
        cmd.rd     = 1'b1;
        state_next = gks_pkg::S_REF_LD;
      end
      gks_pkg::S_REF_LD: begin
        cmd.ref_ld = 1'b1;
        state_next = gks_pkg::S_ROWB;
      end
      gks_pkg::S_ROWB: begin
        any_next   = 1'b0;
        right_next = 1'b1;
        c_next     = q_col;
        state_next = gks_pkg::S_RD;
      end
      gks_pkg::S_RD: begin
        cmd.rd     = 1'b1;
        state_next = gks_pkg::S_CHK;
      end
      gks_pkg::S_CHK: begin
        cmd.cur_ld = 1'b1;
        state_next = gks_pkg::S_WIN;
      end
      gks_pkg::S_WIN: begin
        if (!stat.in_win) begin
          hit_next   = 1'b0;
          state_next = gks_pkg::S_STEP;
        end else begin
          hit_next = 1'b1;
          any_next = 1'b1;
          if (stat.cur_valid) begin
            cmd.op     = gks_pkg::MOP_DXX;
            cnt_next   = 3'd1;
            state_next = gks_pkg::S_MUL;
          end else begin
            state_next = gks_pkg::S_STEP;
          end
        end
      end
      gks_pkg::S_MUL: begin
        case (cnt)
          3'd1:    cmd.op = gks_pkg::MOP_SXL;
          3'd2:    cmd.op = gks_pkg::MOP_SXH;
          3'd3:    cmd.op = gks_pkg::MOP_DYY;
          3'd4:    cmd.op = gks_pkg::MOP_SYL;
          default: cmd.op = gks_pkg::MOP_SYH;
        endcase
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd5) begin
          state_next = gks_pkg::S_MWAIT;
        end
      end
      gks_pkg::S_MWAIT: state_next = gks_pkg::S_ROMR;
      gks_pkg::S_ROMR: begin
        cmd.rom_rd = 1'b1;
        state_next = gks_pkg::S_ACC;
      end
      gks_pkg::S_ACC: begin
        cmd.wv_mul = 1'b1;
        state_next = gks_pkg::S_ACC2;
      end
      gks_pkg::S_ACC2: begin
        cmd.acc    = 1'b1;
        state_next = gks_pkg::S_STEP;
      end
      gks_pkg::S_STEP: begin
        // A walk leftward starts one column left of the query column.
        if (right) begin
          if (hit && (CW'(c) + CW'(1) < cols)) begin
            c_next     = c + 1'b1;
            state_next = gks_pkg::S_RD;
          end else begin
            do_left = 1'b1;
          end
        end else if (hit && (c != '0)) begin
          c_next     = c - 1'b1;
          state_next = gks_pkg::S_RD;
        end else begin
          do_rowend = 1'b1;
        end
        if (do_left) begin
          right_next = 1'b0;
          if (q_col != '0) begin
            c_next     = q_col - 1'b1;
            state_next = gks_pkg::S_RD;
          end else begin
            do_rowend = 1'b1;
          end
        end
        if (do_rowend) begin
          if (!any) begin
            do_phase = 1'b1;
          end else if (up) begin
            if (RW'(r) + RW'(1) < rows) begin
              r_next     = r + 1'b1;
              state_next = gks_pkg::S_ROWB;
            end else begin
              do_phase = 1'b1;
            end
          end else if (r != '0) begin
            r_next     = r - 1'b1;
            state_next = gks_pkg::S_ROWB;
          end else begin
            do_phase = 1'b1;
          end
        end
        if (do_phase) begin
          if (up && (q_row != '0)) begin
            up_next    = 1'b0;
            r_next     = q_row - 1'b1;
            state_next = gks_pkg::S_ROWB;
          end else begin
            state_next = gks_pkg::S_FIN;
          end
        end
      end
      gks_pkg::S_FIN: begin
        if (stat.sw_zero) begin
          state_next = gks_pkg::S_RES;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = gks_pkg::S_DIVW;
        end
      end
      gks_pkg::S_DIVW: begin
        if (!stat.div_busy) begin
          state_next = gks_pkg::S_RES;
        end
      end
      gks_pkg::S_RES: begin
        cmd.res_ld = 1'b1;
        state_next = gks_pkg::S_OUT;
      end
      gks_pkg::S_OUT: state_next = gks_pkg::S_IDLE;
      default: state_next = gks_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hdl/gks_checker.sv =====
// Port-level checks on the smoother, bound to the top level.
module gks_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              command,
  input logic              done,
  input logic signed [31:0] smoothed_value,
  input logic              no_weight
);

  // A result word is shown while the block is still busy with its query.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result word shown while idle");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result word held for more than one cycle");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (done && no_weight) |-> (smoothed_value == 32'sd0))
    else $error("empty weight sum with a non-zero result");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command) |=> busy)
    else $error("query word accepted without going busy");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !command) |=> (!busy && !done))
    else $error("load word caused busy or a result");

endmodule

bind gaussian_kernel_smoother_2d gks_checker u_gks_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
  .done(done), .smoothed_value(smoothed_value), .no_weight(no_weight)
);
